### rtl/plti_pkg.sv
// Shared types, widths and codes for the piecewise-linear table interpolator.
// Depends on nothing; the RTL files refer to it by scoped names, the testbench imports it.
package plti_pkg;

  localparam int unsigned MAX_BINS   = 64;
  localparam int unsigned MAX_LEVELS = 128;
  localparam int unsigned BIN_W      = $clog2(MAX_BINS);
  localparam int unsigned LEVEL_W    = $clog2(MAX_LEVELS);
  localparam int unsigned CNT_W      = BIN_W + 1;
  localparam int unsigned COV_AW     = BIN_W + LEVEL_W;
  localparam int unsigned DIST_W     = 32;
  localparam int unsigned COV_W      = 32;
  localparam int unsigned WGT_W      = 17;
  localparam int unsigned CFG_W      = 7;

  localparam logic [WGT_W-1:0] WGT_ONE      = WGT_W'(17'h10000);
  localparam logic [CFG_W-1:0] BINS_RESET   = CFG_W'(MAX_BINS);

  localparam logic [1:0] FUNC_WR_DIST = 2'd0;
  localparam logic [1:0] FUNC_WR_COV  = 2'd1;
  localparam logic [1:0] FUNC_QUERY   = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_BEYOND = 2'd1;
  localparam logic [1:0] STAT_BELOW  = 2'd2;

  typedef struct packed {
    logic [1:0]              func;
    logic [5:0]              bin_index;
    logic [6:0]              level;
    logic [DIST_W-1:0]       distance;
    logic signed [COV_W-1:0] covariance_in;
  } in_t;

  typedef struct packed {
    logic signed [COV_W-1:0] covariance_out;
    logic [1:0]              status;
  } res_t;

  typedef struct packed {
    logic              start;
    logic [DIST_W-1:0] num;
    logic [DIST_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WGT_W-1:0] quot;
  } div_rsp_t;

endpackage

### rtl/plti_div.sv
// Restoring divider for the interpolation weight: (num * 2^16 + den / 2) / den.
// Requires num < den, so the quotient fits 17 bits. Uses plti_pkg.
module plti_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  plti_pkg::div_req_t req_i,
  output plti_pkg::div_rsp_t rsp_o
);

  localparam int unsigned NW = plti_pkg::DIST_W + plti_pkg::WGT_W;

  logic [NW-1:0]                  dividend;
  logic [plti_pkg::DIST_W-1:0]    rem_q, rem_d;
  logic [plti_pkg::WGT_W-1:0]     low_q, low_d;
  logic [plti_pkg::WGT_W-1:0]     quot_q, quot_d;
  logic [plti_pkg::DIST_W-1:0]    den_q, den_d;
  logic [4:0]                     cnt_q, cnt_d;
  logic                           done_q, done_d;
  logic [plti_pkg::DIST_W:0]      trial;
  logic [plti_pkg::DIST_W:0]      diff;
  logic                           qbit;

  assign dividend = {1'b0, req_i.num, 16'b0} + NW'(req_i.den[plti_pkg::DIST_W-1:1]);

  always_comb begin
    trial  = {rem_q, low_q[plti_pkg::WGT_W-1]};
    diff   = trial - {1'b0, den_q};
    qbit   = (trial >= {1'b0, den_q});
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      // top bits are below den, so the remainder starts in range
      rem_d  = dividend[NW-1:plti_pkg::WGT_W];
      low_d  = dividend[plti_pkg::WGT_W-1:0];
      den_d  = req_i.den;
      quot_d = '0;
      cnt_d  = 5'(plti_pkg::WGT_W);
    end else if (cnt_q != 5'd0) begin
      rem_d  = qbit ? diff[plti_pkg::DIST_W-1:0] : trial[plti_pkg::DIST_W-1:0];
      low_d  = {low_q[plti_pkg::WGT_W-2:0], 1'b0};
      quot_d = {quot_q[plti_pkg::WGT_W-2:0], qbit};
      cnt_d  = cnt_q - 5'd1;
      done_d = (cnt_q == 5'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

### rtl/piecewise_linear_table_interp_top.sv
// Piecewise-linear table interpolator, top level. Uses plti_pkg and plti_div.
// Write items never raise busy. A query ends at the first compare when it hits or falls
// below the first bin, after the binary search (one table read per step) when beyond the
// last bin; else it reads both brackets and, unless they are flat, multiplies and sums,
// running the 17-step weight divider first unless the weight clips at 1.0.
// Reset clears control only; both tables hold garbage until written. bins_in_use resets to 64.
module piecewise_linear_table_interp_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  plti_pkg::in_t                   in_i,
  output logic                            done_o,
  output plti_pkg::res_t                  res_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [plti_pkg::CFG_W-1:0]      cfg_data_i
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_SRCH  = 3'd2;
  localparam logic [2:0] S_RDP   = 3'd3;
  localparam logic [2:0] S_RDM   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;
  localparam logic [2:0] S_SUM   = 3'd7;

  localparam int unsigned BW = plti_pkg::BIN_W;
  localparam int unsigned CW = plti_pkg::CNT_W;
  localparam int unsigned DW = plti_pkg::DIST_W;
  localparam int unsigned VW = plti_pkg::COV_W;
  localparam int unsigned WW = plti_pkg::WGT_W;
  localparam int unsigned PW = WW + 1 + VW + 1;
  localparam int unsigned SW = PW + 1;

  // Tables: bin distances and covariance (entry = bin * MAX_LEVELS + level)
  logic [DW-1:0] dist_mem [plti_pkg::MAX_BINS];
  logic [VW-1:0] cov_mem  [plti_pkg::MAX_BINS * plti_pkg::MAX_LEVELS];

  logic [BW-1:0]                 dist_raddr;
  logic [plti_pkg::COV_AW-1:0]   cov_raddr;
  logic [DW-1:0]                 dist_rdata_q;
  logic signed [VW-1:0]          cov_rdata_q;

  logic [2:0]                    state_q, state_d;
  logic [plti_pkg::CFG_W-1:0]    bins_q;
  logic [CW-1:0]                 n_q, n_d, n_norm;
  logic [CW-1:0]                 lo_q, lo_d, hi_q, hi_d, lo_nx, hi_nx;
  logic [BW-1:0]                 mid_q, mid_d, pos_q, pos_d;
  logic [DW-1:0]                 x_q, x_d, dp_q, dp_d;
  logic [plti_pkg::LEVEL_W-1:0]  lev_q, lev_d;
  logic signed [VW-1:0]          cp_q, cp_d;
  logic signed [VW:0]            diff_q, diff_d;
  logic [WW-1:0]                 a_q, a_d;
  logic signed [PW-1:0]          prod_q, prod_d;
  logic signed [SW-1:0]          sum;
  logic signed [SW-17:0]         shifted;
  logic signed [VW-1:0]          sat_val;
  logic [DW-1:0]                 num, den;
  logic                          flat;
  logic                          accept, wr_dist, wr_cov;
  logic                          done_q, done_d;
  plti_pkg::res_t                res_q, res_d;
  plti_pkg::div_req_t            div_req;
  plti_pkg::div_rsp_t            div_rsp;

  assign accept  = start && !busy;
  assign wr_dist = accept && (in_i.func == plti_pkg::FUNC_WR_DIST);
  assign wr_cov  = accept && (in_i.func == plti_pkg::FUNC_WR_COV);

  // Writes land only while idle, never in a query's accept cycle, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (wr_dist) begin
      dist_mem[in_i.bin_index] <= in_i.distance;
    end
    dist_rdata_q <= dist_mem[dist_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_cov) begin
      cov_mem[{in_i.bin_index, in_i.level}] <= in_i.covariance_in;
    end
    cov_rdata_q <= cov_mem[cov_raddr];
  end

  // Clamp bins_in_use to 1..MAX_BINS
  always_comb begin
    if (bins_q == '0) begin
      n_norm = CW'(1);
    end else if (CW'(bins_q) > CW'(plti_pkg::MAX_BINS)) begin
      n_norm = CW'(plti_pkg::MAX_BINS);
    end else begin
      n_norm = CW'(bins_q);
    end
  end

  // One search step: compare the entry at mid and narrow the window
  always_comb begin
    lo_nx = lo_q;
    hi_nx = hi_q;
    if (dist_rdata_q < x_q) begin
      lo_nx = CW'(mid_q) + CW'(1);
    end else begin
      hi_nx = CW'(mid_q);
    end
  end

  assign num  = dp_q - x_q;
  assign den  = dp_q - dist_rdata_q;
  assign flat = (pos_q == '0) || (dp_q <= dist_rdata_q);

  // Blend: c[p] + a * (c[p-1] - c[p]), rounded half up, floor shift, saturate
  assign sum     = {{(SW-VW-16){cp_q[VW-1]}}, cp_q, 16'b0}
                 + {{(SW-PW){prod_q[PW-1]}}, prod_q} + SW'(32768);
  assign shifted = sum[SW-1:16];
  always_comb begin
    if (shifted > $signed({{(SW-16-VW){1'b0}}, 1'b0, {(VW-1){1'b1}}})) begin
      sat_val = {1'b0, {(VW-1){1'b1}}};
    end else if (shifted < $signed({{(SW-16-VW){1'b1}}, 1'b1, {(VW-1){1'b0}}})) begin
      sat_val = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sat_val = shifted[VW-1:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    pos_d      = pos_q;
    x_d        = x_q;
    lev_d      = lev_q;
    dp_d       = dp_q;
    cp_d       = cp_q;
    diff_d     = diff_q;
    a_d        = a_q;
    prod_d     = prod_q;
    done_d     = 1'b0;
    res_d      = res_q;
    dist_raddr = '0;
    cov_raddr  = {pos_q, lev_q};
    div_req.start = 1'b0;
    div_req.num   = num;
    div_req.den   = den;

    case (state_q)
      S_IDLE: begin
        // Keep bin 0 and its covariance streaming so a query sees them next cycle
        dist_raddr = '0;
        cov_raddr  = {BW'(0), in_i.level};
        if (accept && (in_i.func == plti_pkg::FUNC_QUERY)) begin
          x_d     = in_i.distance;
          lev_d   = in_i.level;
          n_d     = n_norm;
          state_d = S_FIRST;
        end
      end
      S_FIRST: begin
        if (x_q == dist_rdata_q) begin
          res_d   = '{covariance_out: cov_rdata_q, status: plti_pkg::STAT_OK};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (x_q < dist_rdata_q) begin
          res_d   = '{covariance_out: '0, status: plti_pkg::STAT_BELOW};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          lo_d       = '0;
          hi_d       = n_q;
          mid_d      = n_q[CW-1:1];
          dist_raddr = n_q[CW-1:1];
          state_d    = S_SRCH;
        end
      end
      S_SRCH: begin
        lo_d = lo_nx;
        hi_d = hi_nx;
        if (lo_nx < hi_nx) begin
          mid_d      = BW'(lo_nx + ((hi_nx - lo_nx) >> 1));
          dist_raddr = BW'(lo_nx + ((hi_nx - lo_nx) >> 1));
        end else if (lo_nx >= n_q) begin
          res_d   = '{covariance_out: '0, status: plti_pkg::STAT_BEYOND};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          pos_d      = lo_nx[BW-1:0];
          dist_raddr = lo_nx[BW-1:0];
          cov_raddr  = {lo_nx[BW-1:0], lev_q};
          state_d    = S_RDP;
        end
      end
      S_RDP: begin
        // Hold the upper bracket, fetch the lower one
        dp_d       = dist_rdata_q;
        cp_d       = cov_rdata_q;
        dist_raddr = pos_q - BW'(1);
        cov_raddr  = {pos_q - BW'(1), lev_q};
        state_d    = S_RDM;
      end
      S_RDM: begin
        diff_d = {cov_rdata_q[VW-1], cov_rdata_q} - {cp_q[VW-1], cp_q};
        if (flat) begin
          res_d   = '{covariance_out: cp_q, status: plti_pkg::STAT_OK};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (num >= den) begin
          a_d     = plti_pkg::WGT_ONE;
          state_d = S_MUL;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          a_d     = div_rsp.quot;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = $signed({1'b0, a_q}) * diff_q;
        state_d = S_SUM;
      end
      S_SUM: begin
        res_d   = '{covariance_out: sat_val, status: plti_pkg::STAT_OK};
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  plti_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      bins_q  <= plti_pkg::BINS_RESET;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        bins_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers need no reset
  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    pos_q  <= pos_d;
    x_q    <= x_d;
    lev_q  <= lev_d;
    dp_q   <= dp_d;
    cp_q   <= cp_d;
    diff_q <= diff_d;
    a_q    <= a_d;
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  // Config beats are taken at any time; the user is to issue them only while idle.
  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign res_o       = res_q;

  // A result beat always appears with the sequencer back in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result beat while busy");

  // Error beats carry zero covariance
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status != plti_pkg::STAT_OK)) |-> (res_o.covariance_out == '0))
    else $error("error beat with nonzero covariance");

  // Only defined status codes leave the block
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.status == plti_pkg::STAT_OK || res_o.status == plti_pkg::STAT_BEYOND
                || res_o.status == plti_pkg::STAT_BELOW))
    else $error("undefined status code");

  // Non-query items never start the sequencer
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (in_i.func != plti_pkg::FUNC_QUERY)) |=> (!busy && !done_o))
    else $error("write item started a lookup");

endmodule

### verif/tb_piecewise_linear_table_interp_top.sv
// Self-checking testbench for piecewise_linear_table_interp_top.
// Depends on plti_pkg and the block's RTL; carries its own interpolation predictor.
module tb_piecewise_linear_table_interp_top;
  import plti_pkg::*;

  // func 3 has no meaning in the block: it must be swallowed without a result
  localparam logic [1:0]         FUNC_UNUSED   = 2'd3;
  localparam logic [LEVEL_W-1:0] DIR_LVL       = 7'd127;
  localparam int                 N_COLS        = 8;
  localparam int                 N_SEGS        = 6;
  localparam int                 SEG_ITEMS     = 275;
  // leave margin for the longest query before touching the register
  localparam int                 SETTLE_CYCLES = 40;
  localparam int                 STALL_LIMIT   = 2000;

  typedef struct {
    in_t  cmd;
    bit   typed;
    res_t want;
  } dir_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  in_t                 in_i        = '0;
  logic                done_o;
  res_t                res_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    cfg_data_i  = '0;

  // shadow copy of the block's tables and register
  logic [DIST_W-1:0]       dist_tab  [MAX_BINS];
  logic signed [COV_W-1:0] cov_tab   [MAX_BINS*MAX_LEVELS];
  bit                      cov_loaded[MAX_BINS*MAX_LEVELS];
  logic [CFG_W-1:0]        bins_cfg  = BINS_RESET;

  // covariance columns that get loaded for every bin, so any query on them is safe
  logic [LEVEL_W-1:0]      col_levels[N_COLS];
  res_t                    expected_q[$];
  dir_row_t                dir_rows  [$];

  logic [CFG_W-1:0] seg_bins[N_SEGS];
  int unsigned      seg_step[N_SEGS] = '{32'h0400_0000, 3, 32'h0400_0000, 1000, 32'h0001_0000, 17};

  int idle_pct     = 8;
  int mismatches   = 0;
  int n_queries    = 0;
  int n_checked    = 0;
  int n_writes     = 0;
  int n_ignored    = 0;
  int n_settings   = 0;
  int stall_cycles = 0;

  piecewise_linear_table_interp_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // register value 0 acts as one bin, anything above the table size as the full table
  function automatic int bins_active();
    if (bins_cfg == '0) return 1;
    if (bins_cfg > MAX_BINS) return MAX_BINS;
    return int'(bins_cfg);
  endfunction

  function automatic int cov_addr(int b, logic [LEVEL_W-1:0] l);
    return b * MAX_LEVELS + int'(l);
  endfunction

  // Work out the query result; upper/lower report which covariance bins the result uses
  // (-1 where none), so stimulus can avoid touching entries never loaded.
  function automatic void interp_covariance(input logic [LEVEL_W-1:0] lvl,
                                            input logic [DIST_W-1:0] x,
                                            output res_t r, output int upper,
                                            output int lower);
    int     n, lo, hi, mid;
    longint num, den, wgt, acc;
    n      = bins_active();
    r      = '0;
    upper  = -1;
    lower  = -1;
    if (x == dist_tab[0]) begin
      // exact hit on the first bin returns it unweighted
      r.covariance_out = cov_tab[cov_addr(0, lvl)];
      upper = 0;
      return;
    end
    if (x < dist_tab[0]) begin
      r.status = STAT_BELOW;
      return;
    end
    // first bin whose distance is not below the query
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (dist_tab[mid] < x) lo = mid + 1;
      else hi = mid;
    end
    if (lo >= n) begin
      r.status = STAT_BEYOND;
      return;
    end
    upper = lo;
    // unsorted neighbors: no interpolation, take the found bin as is
    if (lo == 0 || dist_tab[lo] <= dist_tab[lo-1]) begin
      r.covariance_out = cov_tab[cov_addr(lo, lvl)];
      return;
    end
    lower = lo - 1;
    num   = longint'(dist_tab[lo] - x);
    den   = longint'(dist_tab[lo] - dist_tab[lo-1]);
    // Q1.16 weight of the lower bin, rounded, clipped at 1.0
    wgt   = (num >= den) ? 64'sd65536 : ((num <<< 16) + den / 2) / den;
    if (wgt > 64'sd65536) wgt = 64'sd65536;
    acc   = wgt * longint'(cov_tab[cov_addr(lower, lvl)])
          + (64'sd65536 - wgt) * longint'(cov_tab[cov_addr(lo, lvl)]) + 64'sd32768;
    acc   = acc >>> 16;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    else if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    r.covariance_out = COV_W'(acc);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers (inputs change on the falling edge, handshakes sampled on the rising)
  // ---------------------------------------------------------------------------

  function automatic in_t mk_cmd(logic [1:0] f, logic [5:0] b, logic [LEVEL_W-1:0] l,
                                 logic [DIST_W-1:0] d, logic [COV_W-1:0] c);
    in_t cmd;
    cmd.func          = f;
    cmd.bin_index     = b;
    cmd.level         = l;
    cmd.distance      = d;
    cmd.covariance_in = c;
    return cmd;
  endfunction

  function automatic dir_row_t drow(in_t cmd, bit typed, logic [COV_W-1:0] want_cov,
                                    logic [1:0] want_stat);
    dir_row_t row;
    row.cmd                 = cmd;
    row.typed               = typed;
    row.want.covariance_out = want_cov;
    row.want.status         = want_stat;
    return row;
  endfunction

  // Send one command beat, then update the shadow tables or queue the expected result.
  // Entered and left on a falling edge; start stays high across back-to-back beats.
  task automatic push_cmd(in_t cmd, bit typed, res_t want);
    res_t r;
    int   up, dn;
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    in_i  = cmd;
    do @(posedge clk_i); while (busy);
    case (cmd.func)
      FUNC_WR_DIST: begin
        dist_tab[cmd.bin_index] = cmd.distance;
        n_writes++;
      end
      FUNC_WR_COV: begin
        cov_tab[cov_addr(cmd.bin_index, cmd.level)]    = cmd.covariance_in;
        cov_loaded[cov_addr(cmd.bin_index, cmd.level)] = 1'b1;
        n_writes++;
      end
      FUNC_QUERY: begin
        interp_covariance(cmd.level, cmd.distance, r, up, dn);
        expected_q.push_back(typed ? want : r);
        n_queries++;
      end
      default: n_ignored++;
    endcase
    @(negedge clk_i);
  endtask

  task automatic write_bins(logic [CFG_W-1:0] v);
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    bins_cfg = v;
    n_settings++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Drain outstanding results, then give the block time to finish any trailing work.
  task automatic settle();
    start = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Reload all distance bins in ascending order with the given spacing; on the first
  // call also fill every bin of the chosen covariance columns.
  task automatic load_table(int unsigned step, bit with_cols);
    longint      d;
    int unsigned off;
    for (int b = 0; b < MAX_BINS; b++) begin
      off = (step > 1) ? $urandom_range(step - 2) : 0;
      d   = longint'(b) * longint'(step) + 1 + longint'(off);
      push_cmd(mk_cmd(FUNC_WR_DIST, 6'(b), LEVEL_W'($urandom), DIST_W'(d), $urandom),
               1'b0, '0);
    end
    if (with_cols) begin
      for (int i = 0; i < N_COLS; i++) begin
        for (int b = 0; b < MAX_BINS; b++) begin
          push_cmd(mk_cmd(FUNC_WR_COV, 6'(b), col_levels[i], $urandom, $urandom), 1'b0, '0);
        end
      end
    end
  endtask

  // One random beat: mostly queries aimed at the table's structure, plus table updates
  // that mostly keep the distances sorted, and a little noise.
  task automatic send_random(output bit counted);
    in_t              cmd;
    res_t             r;
    int               n, k, up, dn;
    int unsigned      pick;
    longint           lo, hi;
    longint unsigned  rnd;
    n       = bins_active();
    cmd     = mk_cmd(FUNC_QUERY, 6'($urandom), LEVEL_W'($urandom), $urandom, $urandom);
    pick    = $urandom_range(99);
    counted = 1'b1;
    if (pick < 3) begin
      cmd.func = FUNC_UNUSED;
      counted  = 1'b0;
    end else if (pick < 20) begin
      cmd.func = FUNC_WR_DIST;
      k        = cmd.bin_index;
      // keep the bin between its neighbors most of the time; otherwise break the order
      if ($urandom_range(19) != 0) begin
        lo  = (k == 0) ? 64'sd0 : longint'(dist_tab[k-1]) + 1;
        hi  = (k == MAX_BINS - 1) ? 64'sh0_FFFF_FFFF : longint'(dist_tab[k+1]) - 1;
        rnd = {$urandom, $urandom};
        cmd.distance = (lo <= hi) ? DIST_W'(lo + longint'(rnd % longint'(hi - lo + 1)))
                                  : dist_tab[k];
      end
    end else if (pick < 40) begin
      cmd.func = FUNC_WR_COV;
      if ($urandom_range(1) != 0) cmd.level = col_levels[$urandom_range(N_COLS - 1)];
      case ($urandom_range(9))
        0:       cmd.covariance_in = 32'sh7FFF_FFFF;
        1:       cmd.covariance_in = 32'sh8000_0000;
        2:       cmd.covariance_in = '0;
        default: ;
      endcase
    end else begin
      k = $urandom_range(n - 1);
      case ($urandom_range(9))
        0: cmd.distance = dist_tab[k];
        1: cmd.distance = dist_tab[0];
        2: if (dist_tab[0] != '0) cmd.distance = $urandom_range(dist_tab[0] - 1, 0);
        3: if (dist_tab[n-1] != '1)
             cmd.distance = $urandom_range(32'hFFFF_FFFF, dist_tab[n-1] + 1);
        4: ;
        5: cmd.distance = ($urandom_range(1) != 0) ? '1 : '0;
        default:
          if (k > 0 && dist_tab[k] > dist_tab[k-1])
            cmd.distance = $urandom_range(dist_tab[k], dist_tab[k-1] + 1);
      endcase
      if ($urandom_range(1) != 0) cmd.level = col_levels[$urandom_range(N_COLS - 1)];
      // never make the block read a covariance entry nobody has written
      interp_covariance(cmd.level, cmd.distance, r, up, dn);
      if ((up >= 0 && !cov_loaded[cov_addr(up, cmd.level)]) ||
          (dn >= 0 && !cov_loaded[cov_addr(dn, cmd.level)]))
        cmd.level = col_levels[$urandom_range(N_COLS - 1)];
    end
    push_cmd(cmd, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest pending expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: cov %h status %0d", res_o.covariance_out, res_o.status);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (res_o.covariance_out !== want.covariance_out || res_o.status !== want.status) begin
          if (mismatches < 10)
            $display("result %0d: expected cov %h status %0d, got cov %h status %0d",
                     n_checked, want.covariance_out, want.status,
                     res_o.covariance_out, res_o.status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles without any beat on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending",
               stall_cycles, expected_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    bit counted;
    int sent;

    col_levels = '{7'd0, 7'd127, 7'h55, 7'h2A, 7'd1, 7'd64,
                   LEVEL_W'($urandom), LEVEL_W'($urandom)};
    // both extremes of the bin count, plus over-range and zero values
    seg_bins   = '{7'd64, 7'd1, 7'd127, 7'd0, CFG_W'($urandom_range(63, 2)), 7'd2};

    // Directed table on four bins at the top level; expected values are spelled out
    // where the answer is obvious, everything else goes through the predictor.
    dir_rows.push_back(drow(mk_cmd(FUNC_WR_DIST, 6'd0, DIR_LVL, 32'd100, '0), 0, '0, STAT_OK));
    dir_rows.push_back(drow(mk_cmd(FUNC_WR_DIST, 6'd1, DIR_LVL, 32'd200, '0), 0, '0, STAT_OK));
    dir_rows.push_back(drow(mk_cmd(FUNC_WR_DIST, 6'd2, DIR_LVL, 32'd400, '0), 0, '0, STAT_OK));
    dir_rows.push_back(drow(mk_cmd(FUNC_WR_DIST, 6'd3, DIR_LVL, 32'hFFFF_FFF0, '0),
                            0, '0, STAT_OK));
    dir_rows.push_back(drow(mk_cmd(FUNC_WR_COV, 6'd0, DIR_LVL, '0, 32'h7FFF_FFFF),
                            0, '0, STAT_OK));
    dir_rows.push_back(drow(mk_cmd(FUNC_WR_COV, 6'd1, DIR_LVL, '0, 32'h8000_0000),
                            0, '0, STAT_OK));
    dir_rows.push_back(drow(mk_cmd(FUNC_WR_COV, 6'd2, DIR_LVL, '0, 32'h0001_0000),
                            0, '0, STAT_OK));
    dir_rows.push_back(drow(mk_cmd(FUNC_WR_COV, 6'd3, DIR_LVL, '0, 32'hFFFF_0000),
                            0, '0, STAT_OK));
    dir_rows.push_back(drow(mk_cmd(FUNC_WR_COV, 6'd63, 7'd0, '1, 32'h1234_5678),
                            0, '0, STAT_OK));
    // exact first bin, below it, past the last bin, exact hits further up
    dir_rows.push_back(drow(mk_cmd(FUNC_QUERY, '0, DIR_LVL, 32'd100, '0),
                            1, 32'h7FFF_FFFF, STAT_OK));
    dir_rows.push_back(drow(mk_cmd(FUNC_QUERY, '1, DIR_LVL, 32'd99, '1), 1, '0, STAT_BELOW));
    dir_rows.push_back(drow(mk_cmd(FUNC_QUERY, '0, DIR_LVL, 32'd0, '0), 1, '0, STAT_BELOW));
    dir_rows.push_back(drow(mk_cmd(FUNC_QUERY, '0, DIR_LVL, 32'hFFFF_FFFF, '0),
                            1, '0, STAT_BEYOND));
    dir_rows.push_back(drow(mk_cmd(FUNC_QUERY, '0, DIR_LVL, 32'd200, '0),
                            1, 32'h8000_0000, STAT_OK));
    dir_rows.push_back(drow(mk_cmd(FUNC_QUERY, '0, DIR_LVL, 32'hFFFF_FFF0, '0),
                            1, 32'hFFFF_0000, STAT_OK));
    // interpolations: midpoint, near each end of a bin, across the huge last gap
    dir_rows.push_back(drow(mk_cmd(FUNC_QUERY, '0, DIR_LVL, 32'd150, '0), 0, '0, STAT_OK));
    dir_rows.push_back(drow(mk_cmd(FUNC_QUERY, '0, DIR_LVL, 32'd101, '0), 0, '0, STAT_OK));
    dir_rows.push_back(drow(mk_cmd(FUNC_QUERY, '0, DIR_LVL, 32'd399, '0), 0, '0, STAT_OK));
    dir_rows.push_back(drow(mk_cmd(FUNC_QUERY, '0, DIR_LVL, 32'd401, '0), 0, '0, STAT_OK));
    // unused function code with every field loaded: must be dropped silently
    dir_rows.push_back(drow(mk_cmd(FUNC_UNUSED, '1, '1, '1, 32'h8000_0000), 0, '0, STAT_OK));
    // first bin at zero: a zero query becomes an exact first-bin hit
    dir_rows.push_back(drow(mk_cmd(FUNC_WR_DIST, 6'd0, DIR_LVL, 32'd0, '0), 0, '0, STAT_OK));
    dir_rows.push_back(drow(mk_cmd(FUNC_QUERY, '0, DIR_LVL, 32'd0, '0),
                            1, 32'h7FFF_FFFF, STAT_OK));

    // hold reset, then release it on a falling edge
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_bins(7'd4);
    foreach (dir_rows[i]) push_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

    // Random segments: sender idles 8% for two, 75% for two, never for the last two;
    // each segment changes the bin count and reloads the distances with its own spacing.
    for (int s = 0; s < N_SEGS; s++) begin
      settle();
      idle_pct = (s < 2) ? 8 : (s < 4) ? 75 : 0;
      write_bins(seg_bins[s]);
      load_table(seg_step[s], s == 0);
      sent = 0;
      while (sent < SEG_ITEMS) begin
        send_random(counted);
        if (counted) sent++;
      end
    end

    settle();
    $display("checked %0d query results against %0d issued, %0d table writes, %0d dropped",
             n_checked, n_queries, n_writes, n_ignored);
    $display("ran under %0d bin-count settings incl. 0, 1, 64 and 127", n_settings);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/plti_pkg.sv
rtl/plti_div.sv
rtl/piecewise_linear_table_interp_top.sv
verif/tb_piecewise_linear_table_interp_top.sv
